// File: rtl/mrh_pkg.sv
// Package: shared constants, types and configuration layout for the masked range histogram.
package mrh_pkg;

    localparam int DEFAULT_NUM_BINS    = 256;
    localparam int DEFAULT_COUNT_BITS  = 24;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam int CMD_W       = 2;
    localparam int SEL_W       = 8;
    localparam int HIT_W       = 8;
    localparam int HEIGHT_W    = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int MIN_W       = 16;
    localparam int STEP_W      = 24;
    localparam int USED_W      = 9;
    localparam int PLOT_W      = 11;
    localparam int SCALE_W     = 24;
    localparam int FRAC_BITS   = 16;
    localparam int OP_W        = 3;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_VALUE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_STEP     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BINS_IN_USE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLOT_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_SCALE = 3'd4;

    localparam logic signed [MIN_W-1:0] RST_MIN_VALUE    = 16'sd0;
    localparam logic [STEP_W-1:0]       RST_INV_STEP     = 24'd65536;
    localparam logic [USED_W-1:0]       RST_BINS_IN_USE  = 9'd256;
    localparam logic [PLOT_W-1:0]       RST_PLOT_HEIGHT  = 11'd256;
    localparam logic [SCALE_W-1:0]      RST_HEIGHT_SCALE = 24'd65536;

    localparam logic [PLOT_W-1:0]   PLOT_MAX   = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_TOP = 10'd1023;

    typedef enum logic [OP_W-1:0] {
        OP_ADD,
        OP_READ,
        OP_VOID_READ,
        OP_CLEAR,
        OP_PASS
    } mrh_op_t;

    typedef struct packed {
        logic signed [MIN_W-1:0] min_value;
        logic [STEP_W-1:0]       inv_step;
        logic [USED_W-1:0]       bins_in_use;
        logic [PLOT_W-1:0]       plot_height;
        logic [SCALE_W-1:0]      height_scale;
    } mrh_cfg_t;

endpackage

// File: rtl/mrh_if.sv
// Interfaces: sample channel and result channel with valid/ready handshake.
interface mrh_in_if #(
    parameter int SAMPLE_BITS = mrh_pkg::DEFAULT_SAMPLE_BITS
);
    logic                             valid;
    logic                             ready;
    logic [mrh_pkg::CMD_W-1:0]        cmd;
    logic signed [SAMPLE_BITS-1:0]    sample_value;
    logic                             masked_out;
    logic                             row_start;
    logic [mrh_pkg::SEL_W-1:0]        bin_select;

    modport source (
        output valid, cmd, sample_value, masked_out, row_start, bin_select,
        input  ready
    );
    modport sink (
        input  valid, cmd, sample_value, masked_out, row_start, bin_select,
        output ready
    );
endinterface

interface mrh_out_if #(
    parameter int COUNT_BITS = mrh_pkg::DEFAULT_COUNT_BITS
);
    logic                             valid;
    logic                             ready;
    logic [mrh_pkg::HIT_W-1:0]        bin_hit;
    logic [COUNT_BITS-1:0]            bin_total;
    logic [mrh_pkg::HEIGHT_W-1:0]     scaled_height;
    logic [COUNT_BITS-1:0]            peak_count;
    logic                             sample_counted;

    modport source (
        output valid, bin_hit, bin_total, scaled_height, peak_count, sample_counted,
        input  ready
    );
    modport sink (
        input  valid, bin_hit, bin_total, scaled_height, peak_count, sample_counted,
        output ready
    );
endinterface

// File: rtl/masked_range_histogram.sv
// Top level: masked range histogram with configuration registers, front, queue and back.
//
//   channel   | role   | payload                                                  | transfer
//   ----------+--------+----------------------------------------------------------+--------------
//   samples   | sink   | cmd, sample_value, masked_out, row_start, bin_select      | valid & ready
//   results   | source | bin_hit, bin_total, scaled_height, peak_count, sample_cnt | valid & ready
//   cfg       | write  | cfg_index, cfg_data                                       | cfg_we
//
// The front registers each item before it enters the queue; the back runs adds and in-range reads
// through memory read, update, height multiply and result, and takes clears, out-of-range reads
// and ignored items straight to the result. The back takes a new item only once the last one's
// result is registered. After reset and after each clear the count memory is swept to zero,
// with samples held off; configuration writes are taken throughout.
// A stalled result register holds the back; the queue lets the front accept until it is full.
module masked_range_histogram #(
    parameter int NUM_BINS    = mrh_pkg::DEFAULT_NUM_BINS,
    parameter int COUNT_BITS  = mrh_pkg::DEFAULT_COUNT_BITS,
    parameter int SAMPLE_BITS = mrh_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mrh_in_if.sink                             samples,
    mrh_out_if.source                          results,
    input  logic                               cfg_we,
    input  logic [mrh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mrh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int ENTRY_W = mrh_pkg::OP_W + BIN_W + mrh_pkg::HIT_W;

    mrh_pkg::mrh_cfg_t    cfg_reg;
    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_valid;
    logic [ENTRY_W-1:0]   q_wdata;
    logic [ENTRY_W-1:0]   q_rdata;
    logic                 sweep_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_value    <= mrh_pkg::RST_MIN_VALUE;
            cfg_reg.inv_step     <= mrh_pkg::RST_INV_STEP;
            cfg_reg.bins_in_use  <= mrh_pkg::RST_BINS_IN_USE;
            cfg_reg.plot_height  <= mrh_pkg::RST_PLOT_HEIGHT;
            cfg_reg.height_scale <= mrh_pkg::RST_HEIGHT_SCALE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mrh_pkg::CFG_MIN_VALUE:
                    cfg_reg.min_value    <= cfg_data[mrh_pkg::MIN_W-1:0];
                mrh_pkg::CFG_INV_STEP:
                    cfg_reg.inv_step     <= cfg_data[mrh_pkg::STEP_W-1:0];
                mrh_pkg::CFG_BINS_IN_USE:
                    cfg_reg.bins_in_use  <= cfg_data[mrh_pkg::USED_W-1:0];
                mrh_pkg::CFG_PLOT_HEIGHT:
                    cfg_reg.plot_height  <= cfg_data[mrh_pkg::PLOT_W-1:0];
                mrh_pkg::CFG_HEIGHT_SCALE:
                    cfg_reg.height_scale <= cfg_data[mrh_pkg::SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mrh_front #(
        .NUM_BINS    (NUM_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .samples    (samples),
        .sweep_busy (sweep_busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    mrh_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (mrh_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_valid)
    );

    mrh_back #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .sweep_busy (sweep_busy),
        .results    (results)
    );

endmodule

// File: rtl/mrh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mrh_queue.sv
// Short FIFO between the classifying front and the executing back.
module mrh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mrh_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[head_reg];

endmodule

// File: rtl/mrh_front.sv
// Front: accept items, track the row stop, compute and clamp the bin, queue the operation.
module mrh_front #(
    parameter int NUM_BINS    = mrh_pkg::DEFAULT_NUM_BINS,
    parameter int SAMPLE_BITS = mrh_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  mrh_pkg::mrh_cfg_t                          cfg,
    mrh_in_if.sink                                     samples,
    input  logic                                       sweep_busy,
    input  logic                                       q_full,
    output logic                                       q_push,
    output logic [mrh_pkg::OP_W+$clog2(NUM_BINS)+mrh_pkg::HIT_W-1:0] q_data
);

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int SW     = ((SAMPLE_BITS > mrh_pkg::MIN_W) ? SAMPLE_BITS : mrh_pkg::MIN_W) + 1;
    localparam int DIFF_W = SW - 1;
    localparam int PROD_W = DIFF_W + mrh_pkg::STEP_W;
    localparam int RAW_W  = PROD_W - mrh_pkg::FRAC_BITS;
    localparam int CMP_W  = ((BIN_W + 1) > mrh_pkg::USED_W) ? (BIN_W + 2) : (mrh_pkg::USED_W + 1);
    localparam logic [CMP_W-1:0] NB_CMP = CMP_W'(NUM_BINS);

    logic                         s1_valid_reg;
    mrh_pkg::mrh_op_t             s1_op_reg;
    logic [DIFF_W-1:0]            s1_diff_reg;
    logic [BIN_W-1:0]             s1_bin_reg;
    logic [mrh_pkg::HIT_W-1:0]    s1_hit_reg;
    logic                         s2_valid_reg;
    mrh_pkg::mrh_op_t             s2_op_reg;
    logic [PROD_W-1:0]            s2_prod_reg;
    logic [BIN_W-1:0]             s2_bin_reg;
    logic [mrh_pkg::HIT_W-1:0]    s2_hit_reg;
    logic                         stopped_reg, stopped_next;

    logic                         accept;
    logic                         s1_free;
    logic                         s2_free;
    logic signed [SW-1:0]         diff;
    logic [DIFF_W-1:0]            diff_pos;
    mrh_pkg::mrh_op_t             op_in;
    logic [BIN_W-1:0]             bin_in;
    logic [mrh_pkg::HIT_W-1:0]    hit_in;
    logic [CMP_W-1:0]             used_cmp;
    logic [CMP_W-1:0]             sel_cmp;
    logic [BIN_W-1:0]             last_bin;
    logic [RAW_W-1:0]             raw_bin;
    logic [BIN_W-1:0]             bin_out;
    logic [mrh_pkg::HIT_W-1:0]    hit_out;

    assign q_push  = s2_valid_reg && !q_full;
    assign s2_free = !s2_valid_reg || q_push;
    assign s1_free = !s1_valid_reg || s2_free;
    assign samples.ready = s1_free && !sweep_busy;
    assign accept  = samples.valid && samples.ready;

    assign diff     = SW'(samples.sample_value) - SW'(cfg.min_value);
    assign diff_pos = (diff > 0) ? diff[DIFF_W-1:0] : '0;
    assign sel_cmp  = CMP_W'(samples.bin_select);

    always_comb
    begin
        stopped_next = stopped_reg;
        op_in        = mrh_pkg::OP_PASS;
        bin_in       = '0;
        hit_in       = '0;
        unique case (samples.cmd)
            mrh_pkg::CMD_ADD:
            begin
                stopped_next = (stopped_reg && !samples.row_start) || samples.masked_out;
                op_in        = stopped_next ? mrh_pkg::OP_PASS : mrh_pkg::OP_ADD;
            end
            mrh_pkg::CMD_READ:
            begin
                op_in  = (sel_cmp < NB_CMP) ? mrh_pkg::OP_READ : mrh_pkg::OP_VOID_READ;
                bin_in = BIN_W'(samples.bin_select);
                hit_in = samples.bin_select;
            end
            mrh_pkg::CMD_CLEAR:
            begin
                op_in = mrh_pkg::OP_CLEAR;
            end
            default:
            begin
                op_in = mrh_pkg::OP_PASS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (accept)
            begin
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= op_in;
            s1_diff_reg <= diff_pos;
            s1_bin_reg  <= bin_in;
            s1_hit_reg  <= hit_in;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_prod_reg <= PROD_W'(s1_diff_reg) * PROD_W'(cfg.inv_step);
            s2_bin_reg  <= s1_bin_reg;
            s2_hit_reg  <= s1_hit_reg;
        end
    end

    // clamp the bin into the range in use
    assign used_cmp = CMP_W'(cfg.bins_in_use);
    always_comb
    begin
        if (used_cmp == '0)
        begin
            last_bin = '0;
        end
        else if (used_cmp > NB_CMP)
        begin
            last_bin = BIN_W'(NUM_BINS - 1);
        end
        else
        begin
            last_bin = BIN_W'(used_cmp - 1'b1);
        end
    end

    assign raw_bin = s2_prod_reg[PROD_W-1:mrh_pkg::FRAC_BITS];

    always_comb
    begin
        bin_out = s2_bin_reg;
        hit_out = s2_hit_reg;
        if (s2_op_reg == mrh_pkg::OP_ADD)
        begin
            bin_out = (raw_bin > RAW_W'(last_bin)) ? last_bin : raw_bin[BIN_W-1:0];
            hit_out = mrh_pkg::HIT_W'(bin_out);
        end
    end

    assign q_data = {s2_op_reg, bin_out, hit_out};

    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && q_full) |=> (s2_valid_reg && $stable(s2_prod_reg)))
        else $error("stalled entry lost before queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && s2_op_reg == mrh_pkg::OP_ADD) |-> (bin_out <= last_bin))
        else $error("bin outside range in use");

    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_busy |-> !accept)
        else $error("item taken during clearing pass");

endmodule

// File: rtl/mrh_back.sv
// Back: execute queued operations on the count memory, track the peak, scale the bar height.
module mrh_back #(
    parameter int NUM_BINS   = mrh_pkg::DEFAULT_NUM_BINS,
    parameter int COUNT_BITS = mrh_pkg::DEFAULT_COUNT_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  mrh_pkg::mrh_cfg_t                          cfg,
    input  logic                                       q_valid,
    input  logic [mrh_pkg::OP_W+$clog2(NUM_BINS)+mrh_pkg::HIT_W-1:0] q_data,
    output logic                                       q_pop,
    output logic                                       sweep_busy,
    mrh_out_if.source                                  results
);

    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int ENTRY_W = mrh_pkg::OP_W + BIN_W + mrh_pkg::HIT_W;
    localparam int PROD_W  = COUNT_BITS + mrh_pkg::SCALE_W;
    localparam int RAW_W   = PROD_W - mrh_pkg::FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [BIN_W-1:0]      BIN_LAST  = BIN_W'(NUM_BINS - 1);
    localparam logic [PROD_W-1:0]     ROUND_HALF = PROD_W'(1) << (mrh_pkg::FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_UPDATE,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t                       state_reg;
    mrh_pkg::mrh_op_t             op_reg;
    logic [BIN_W-1:0]             bin_reg;
    logic [mrh_pkg::HIT_W-1:0]    hit_reg;
    logic [COUNT_BITS-1:0]        total_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [COUNT_BITS-1:0]        peak_reg;
    logic [BIN_W-1:0]             sweep_addr_reg;
    logic                         out_valid_reg;
    logic [mrh_pkg::HIT_W-1:0]    out_hit_reg;
    logic [COUNT_BITS-1:0]        out_total_reg;
    logic [mrh_pkg::HEIGHT_W-1:0] out_height_reg;
    logic [COUNT_BITS-1:0]        out_peak_reg;
    logic                         out_counted_reg;

    mrh_pkg::mrh_op_t             q_op;
    logic [BIN_W-1:0]             q_bin;
    logic [mrh_pkg::HIT_W-1:0]    q_hit;
    logic                         ram_we;
    logic [BIN_W-1:0]             ram_waddr;
    logic [COUNT_BITS-1:0]        ram_wdata;
    logic [COUNT_BITS-1:0]        ram_rdata;
    logic [COUNT_BITS-1:0]        cnt_next;
    logic                         emit_fire;
    logic [PROD_W-1:0]            rounded;
    logic [RAW_W-1:0]             raw_height;
    logic [mrh_pkg::HEIGHT_W-1:0] height_limit;
    logic [mrh_pkg::HEIGHT_W-1:0] height;

    assign q_op  = mrh_pkg::mrh_op_t'(q_data[ENTRY_W-1 -: mrh_pkg::OP_W]);
    assign q_bin = q_data[mrh_pkg::HIT_W +: BIN_W];
    assign q_hit = q_data[mrh_pkg::HIT_W-1:0];

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign sweep_busy = (state_reg == S_SWEEP);

    assign cnt_next = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = bin_reg;
        ram_wdata = cnt_next;
        if (state_reg == S_SWEEP)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_addr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == S_UPDATE && op_reg == mrh_pkg::OP_ADD)
        begin
            ram_we = 1'b1;
        end
    end

    mrh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (q_pop),
        .raddr (q_bin),
        .rdata (ram_rdata)
    );

    // round, then limit to plot height minus one
    assign rounded    = prod_reg + ROUND_HALF;
    assign raw_height = rounded[PROD_W-1:mrh_pkg::FRAC_BITS];

    always_comb
    begin
        if (cfg.plot_height == '0)
        begin
            height_limit = '0;
        end
        else if (cfg.plot_height > mrh_pkg::PLOT_MAX)
        begin
            height_limit = mrh_pkg::HEIGHT_TOP;
        end
        else
        begin
            height_limit = mrh_pkg::HEIGHT_W'(cfg.plot_height - 1'b1);
        end
        height = (raw_height > RAW_W'(height_limit)) ? height_limit
                                                     : raw_height[mrh_pkg::HEIGHT_W-1:0];
    end

    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_addr_reg <= '0;
            peak_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SWEEP:
                begin
                    if (sweep_addr_reg == BIN_LAST)
                    begin
                        sweep_addr_reg <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        sweep_addr_reg <= sweep_addr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg    <= q_op;
                        bin_reg   <= q_bin;
                        hit_reg   <= q_hit;
                        total_reg <= '0;
                        prod_reg  <= '0;
                        if (q_op == mrh_pkg::OP_ADD || q_op == mrh_pkg::OP_READ)
                        begin
                            state_reg <= S_UPDATE;
                        end
                        else
                        begin
                            if (q_op == mrh_pkg::OP_CLEAR)
                            begin
                                peak_reg <= '0;
                            end
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_UPDATE:
                begin
                    if (op_reg == mrh_pkg::OP_ADD)
                    begin
                        total_reg <= cnt_next;
                        if (cnt_next > peak_reg)
                        begin
                            peak_reg <= cnt_next;
                        end
                    end
                    else
                    begin
                        total_reg <= ram_rdata;
                    end
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    prod_reg  <= PROD_W'(total_reg) * PROD_W'(cfg.height_scale);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_hit_reg     <= hit_reg;
                        out_total_reg   <= total_reg;
                        out_height_reg  <= height;
                        out_peak_reg    <= peak_reg;
                        out_counted_reg <= (op_reg == mrh_pkg::OP_ADD);
                        state_reg       <= (op_reg == mrh_pkg::OP_CLEAR) ? S_SWEEP : S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.bin_hit        = out_hit_reg;
    assign results.bin_total      = out_total_reg;
    assign results.scaled_height  = out_height_reg;
    assign results.peak_count     = out_peak_reg;
    assign results.sample_counted = out_counted_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SWEEP || state_reg == S_UPDATE))
        else $error("count memory written outside update or sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && op_reg == mrh_pkg::OP_ADD) |=> (peak_reg >= $past(cnt_next)))
        else $error("peak below a fresh count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && op_reg == mrh_pkg::OP_CLEAR) |=> (state_reg == S_SWEEP && peak_reg == '0))
        else $error("clear not followed by sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && op_reg != mrh_pkg::OP_ADD && op_reg != mrh_pkg::OP_READ)
            |-> (total_reg == '0 && prod_reg == '0))
        else $error("non-memory result carries a count");

endmodule

// File: tb/sv/tb_masked_range_histogram.sv
// Testbench: drives sample and command transfers into the histogram and checks every result.
module tb_masked_range_histogram;
    import mrh_pkg::*;

    localparam int NUM_BINS      = DEFAULT_NUM_BINS;
    localparam int COUNT_BITS    = DEFAULT_COUNT_BITS;
    localparam int SAMPLE_BITS   = DEFAULT_SAMPLE_BITS;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic [HIT_W-1:0]      bin_hit;
        logic [COUNT_BITS-1:0] bin_total;
        logic [HEIGHT_W-1:0]   scaled_height;
        logic [COUNT_BITS-1:0] peak_count;
        logic                  sample_counted;
    } hist_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mrh_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
    mrh_out_if #(.COUNT_BITS(COUNT_BITS))   results_ch ();

    masked_range_histogram #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    mrh_cfg_t              shadow_cfg;
    logic [COUNT_BITS-1:0] bin_counts_model [NUM_BINS];
    logic [COUNT_BITS-1:0] peak_model;
    logic                  row_stop_model;
    hist_result_t          expected_results [$];

    int unsigned mismatches     = 0;
    int unsigned transfers_sent = 0;
    int unsigned results_seen   = 0;
    int unsigned settings_used  = 0;
    int unsigned cycle_count    = 0;

    bit          pace_tx      = 1'b1;
    bit          pace_rx      = 1'b1;
    bit          hold_results = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned rx_gap       = 0;

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic int bins_used();
        int n;
        n = shadow_cfg.bins_in_use;
        if (n < 1)
            n = 1;
        if (n > NUM_BINS)
            n = NUM_BINS;
        return n;
    endfunction

    function automatic logic [HEIGHT_W-1:0] bar_height_of(logic [COUNT_BITS-1:0] count);
        longint unsigned lim;
        longint unsigned h;
        lim = shadow_cfg.plot_height;
        if (lim < 1)
            lim = 1;
        if (lim > PLOT_MAX)
            lim = PLOT_MAX;
        h = count;
        h = (h * shadow_cfg.height_scale + 64'd32768) >> FRAC_BITS;
        if (h > lim - 1)
            h = lim - 1;
        return h[HEIGHT_W-1:0];
    endfunction

    function automatic hist_result_t apply_to_histogram(
        logic [CMD_W-1:0]              cmd,
        logic signed [SAMPLE_BITS-1:0] sample,
        logic                          masked,
        logic                          first_in_row,
        logic [SEL_W-1:0]              sel
    );
        hist_result_t    r;
        longint          offset;
        longint unsigned bin;
        longint unsigned used;
        int              i;
        r = '0;
        case (cmd)
            CMD_ADD:
            begin
                if (first_in_row)
                    row_stop_model = 1'b0;
                if (masked)
                    row_stop_model = 1'b1;
                if (!row_stop_model)
                begin
                    offset = longint'(sample) - longint'(shadow_cfg.min_value);
                    used = bins_used();
                    bin = 0;
                    if (offset > 0)
                    begin
                        bin = offset;
                        bin = (bin * shadow_cfg.inv_step) >> FRAC_BITS;
                    end
                    if (bin > used - 1)
                        bin = used - 1;
                    if (bin_counts_model[bin] != COUNT_FULL)
                        bin_counts_model[bin] += 1'b1;
                    if (bin_counts_model[bin] > peak_model)
                        peak_model = bin_counts_model[bin];
                    r.bin_hit        = bin[HIT_W-1:0];
                    r.bin_total      = bin_counts_model[bin];
                    r.scaled_height  = bar_height_of(r.bin_total);
                    r.sample_counted = 1'b1;
                end
            end
            CMD_READ:
            begin
                r.bin_hit       = sel;
                r.bin_total     = (sel < NUM_BINS) ? bin_counts_model[sel] : '0;
                r.scaled_height = bar_height_of(r.bin_total);
            end
            CMD_CLEAR:
            begin
                for (i = 0; i < NUM_BINS; i++)
                    bin_counts_model[i] = '0;
                peak_model = '0;
            end
            default: ;
        endcase
        r.peak_count = peak_model;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sample_near_bins();
        longint span;
        longint v;
        span = (longint'(bins_used()) << FRAC_BITS)
               / ((shadow_cfg.inv_step == 0) ? 1 : shadow_cfg.inv_step) + 4;
        if (span > 60000)
            span = 60000;
        v = longint'(shadow_cfg.min_value) - span / 8
            + longint'($urandom_range(0, span + span / 4));
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic check_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic send_item(
        logic [CMD_W-1:0]              cmd,
        logic signed [SAMPLE_BITS-1:0] sample,
        logic                          masked,
        logic                          first_in_row,
        logic [SEL_W-1:0]              sel
    );
        int unsigned gap;
        gap = pace_tx ? idle_length() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            samples_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samples_ch.valid        = 1'b1;
        samples_ch.cmd          = cmd;
        samples_ch.sample_value = sample;
        samples_ch.masked_out   = masked;
        samples_ch.row_start    = first_in_row;
        samples_ch.bin_select   = sel;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        expected_results.push_back(apply_to_histogram(cmd, sample, masked, first_in_row, sel));
        transfers_sent++;
    endtask

    task automatic wait_for_idle();
        @(negedge clk);
        samples_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        samples_ch.valid = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        case (index)
            CFG_MIN_VALUE:    shadow_cfg.min_value    = data[MIN_W-1:0];
            CFG_INV_STEP:     shadow_cfg.inv_step     = data[STEP_W-1:0];
            CFG_BINS_IN_USE:  shadow_cfg.bins_in_use  = data[USED_W-1:0];
            CFG_PLOT_HEIGHT:  shadow_cfg.plot_height  = data[PLOT_W-1:0];
            CFG_HEIGHT_SCALE: shadow_cfg.height_scale = data[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(
        logic [MIN_W-1:0]   min_value,
        logic [STEP_W-1:0]  inv_step,
        logic [USED_W-1:0]  bins_in_use,
        logic [PLOT_W-1:0]  plot_height,
        logic [SCALE_W-1:0] height_scale
    );
        write_reg(CFG_MIN_VALUE, CFG_DATA_W'(min_value));
        write_reg(CFG_INV_STEP, inv_step);
        write_reg(CFG_BINS_IN_USE, CFG_DATA_W'(bins_in_use));
        write_reg(CFG_PLOT_HEIGHT, CFG_DATA_W'(plot_height));
        write_reg(CFG_HEIGHT_SCALE, height_scale);
        settings_used++;
    endtask

    task automatic stream_rows(int unsigned n_items);
        int unsigned left;
        int unsigned row_len;
        int unsigned k;
        int unsigned pick;
        logic        masked;
        logic        first_in_row;
        logic [SEL_W-1:0] sel;
        left = n_items;
        while (left > 0)
        begin
            row_len = $urandom_range(1, 12);
            for (k = 0; k < row_len && left > 0; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_item($urandom, $urandom, $urandom, $urandom, $urandom);
                else if (pick < 14)
                begin
                    sel = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, bins_used() - 1);
                    send_item(CMD_READ, $urandom, $urandom, $urandom, sel);
                end
                else if (pick < 16)
                    send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
                else
                begin
                    first_in_row = (k == 0) || ($urandom_range(0, 19) == 0);
                    masked = ($urandom_range(0, 14) == 0);
                    if ($urandom_range(0, 9) < 7)
                        send_item(CMD_ADD, sample_near_bins(), masked, first_in_row, $urandom);
                    else
                        send_item(CMD_ADD, $urandom, masked, first_in_row, $urandom);
                end
                left--;
            end
        end
    endtask

    task automatic test_bin_edges();
        send_item(CMD_ADD, 16'sd0, 1'b0, 1'b1, 8'd0);
        send_item(CMD_ADD, 16'sh8000, 1'b0, 1'b0, 8'd0);
        send_item(CMD_ADD, 16'sh7FFF, 1'b0, 1'b0, 8'd0);
        send_item(CMD_ADD, 16'sd5, 1'b0, 1'b0, 8'd0);
        send_item(CMD_ADD, 16'sd255, 1'b0, 1'b0, 8'd0);
        send_item(CMD_ADD, 16'sd256, 1'b0, 1'b0, 8'd0);
        send_item(CMD_READ, 16'sd0, 1'b0, 1'b0, 8'd5);
        send_item(CMD_READ, 16'sd0, 1'b0, 1'b0, 8'd255);
        send_item(CMD_READ, 16'sd0, 1'b0, 1'b0, 8'd0);
        send_item(CMD_READ, 16'sd0, 1'b0, 1'b0, 8'd200);
    endtask

    task automatic test_row_stop();
        send_item(CMD_ADD, 16'sd10, 1'b0, 1'b1, 8'd0);
        send_item(CMD_ADD, 16'sd11, 1'b1, 1'b0, 8'd0);
        send_item(CMD_ADD, 16'sd12, 1'b0, 1'b0, 8'd0);
        send_item(CMD_READ, 16'sd0, 1'b0, 1'b1, 8'd10);
        send_item(CMD_ADD, 16'sd13, 1'b0, 1'b0, 8'd0);
        send_item(CMD_ADD, 16'sd13, 1'b0, 1'b1, 8'd0);
        send_item(CMD_ADD, 16'sd14, 1'b1, 1'b1, 8'd0);
        send_item(CMD_ADD, 16'sd15, 1'b0, 1'b1, 8'd0);
    endtask

    task automatic test_clear_and_unused();
        send_item(CMD_UNUSED, 16'sh7FFF, 1'b1, 1'b1, 8'hFF);
        send_item(CMD_CLEAR, 16'sd0, 1'b0, 1'b0, 8'd0);
        send_item(CMD_READ, 16'sd0, 1'b0, 1'b0, 8'd5);
        send_item(CMD_ADD, 16'sd7, 1'b0, 1'b1, 8'd0);
        send_item(CMD_READ, 16'sd0, 1'b0, 1'b0, 8'd7);
    endtask

    task automatic test_backpressure();
        pace_tx = 1'b0;
        pace_rx = 1'b0;
        hold_results = 1'b1;
        stream_rows(30);
        wait_for_idle();
        stream_rows(20);
        wait_for_idle();
        pace_tx = 1'b1;
        pace_rx = 1'b1;
    endtask

    task automatic test_random_settings();
        int unsigned phase;
        for (phase = 0; phase < 8; phase++)
        begin
            wait_for_idle();
            case (phase)
                0: apply_settings(16'h8000, 24'hFFFFFF, 9'd0, 11'd0, 24'd0);
                1: apply_settings(16'h7FFF, 24'd0, 9'h1FF, 11'h7FF, 24'hFFFFFF);
                2: apply_settings(16'h8000, 24'd1, 9'd1, 11'd1024, 24'hFFFFFF);
                3: apply_settings(16'h8000, 24'd256, 9'h1FF, 11'd1024, 24'd1 << 20);
                default:
                    apply_settings(
                        $urandom,
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 10, 1 << 19),
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(2, 40),
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(2, 200),
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1 << 12, 1 << 21));
            endcase
            stream_rows((phase < 3) ? 25 : 60);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_results)
        begin
            hold_left    = HOLD_CYCLES;
            hold_results = 1'b0;
        end
        if (hold_left > 0)
        begin
            results_ch.ready = 1'b0;
            hold_left--;
        end
        else if (rx_gap > 0)
        begin
            results_ch.ready = 1'b0;
            rx_gap--;
        end
        else
        begin
            results_ch.ready = 1'b1;
            if (pace_rx)
                rx_gap = idle_length();
        end
    end

    always @(posedge clk)
    begin : check_results
        hist_result_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing outstanding: bin_hit %0d",
                       results_ch.bin_hit);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("bin_hit", want.bin_hit, results_ch.bin_hit);
                check_field("bin_total", want.bin_total, results_ch.bin_total);
                check_field("scaled_height", want.scaled_height, results_ch.scaled_height);
                check_field("peak_count", want.peak_count, results_ch.peak_count);
                check_field("sample_counted", want.sample_counted, results_ch.sample_counted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        samples_ch.valid        = 1'b0;
        samples_ch.cmd          = CMD_ADD;
        samples_ch.sample_value = '0;
        samples_ch.masked_out   = 1'b0;
        samples_ch.row_start    = 1'b0;
        samples_ch.bin_select   = '0;
        results_ch.ready        = 1'b0;
        shadow_cfg.min_value    = RST_MIN_VALUE;
        shadow_cfg.inv_step     = RST_INV_STEP;
        shadow_cfg.bins_in_use  = RST_BINS_IN_USE;
        shadow_cfg.plot_height  = RST_PLOT_HEIGHT;
        shadow_cfg.height_scale = RST_HEIGHT_SCALE;
        for (i = 0; i < NUM_BINS; i++)
            bin_counts_model[i] = '0;
        peak_model     = '0;
        row_stop_model = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_bin_edges();
        test_row_stop();
        test_clear_and_unused();
        test_backpressure();
        test_random_settings();
        wait_for_idle();

        $display("%0d transfers sent, %0d results checked, %0d register settings applied",
                 transfers_sent, results_seen, settings_used);
        $display("covered clamping at both ends, row stops, reads, clears and stalls");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mrh_pkg.sv
rtl/mrh_if.sv
rtl/mrh_ram.sv
rtl/mrh_queue.sv
rtl/mrh_front.sv
rtl/mrh_back.sv
rtl/masked_range_histogram.sv
tb/sv/tb_masked_range_histogram.sv
